// ===== design/fam_pkg.sv =====
// ----------------------------------------------------------------------------
// fam_pkg
// Shared types and codes for the fall alarm mode controller: transaction
// payloads, alarm modes, classification, indicator and buzzer codes.
// ----------------------------------------------------------------------------
package fam_pkg;

    localparam int CLASS_W = 3;
    localparam int TIME_W  = 32;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 8;
    localparam int DELAY_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [COUNT_W-1:0] ALARM_CONFIRM_RESET   = 8'd3;
    localparam logic [COUNT_W-1:0] RECOVER_CONFIRM_RESET = 8'd5;
    localparam logic [DELAY_W-1:0] FALL_DELAY_RESET      = 16'd4000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_CONFIRM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_CONFIRM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_DELAY      = 2'd2;

    // Motion classes
    localparam logic [CLASS_W-1:0] CLS_WALK  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_DIZZY = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_FALL  = 3'd4;

    // Indicator codes (standing/sitting/walking equal the class code)
    localparam logic [CODE_W-1:0] IND_STANDING   = 3'd0;
    localparam logic [CODE_W-1:0] IND_DIZZY      = 3'd3;
    localparam logic [CODE_W-1:0] IND_ALARMED    = 3'd4;
    localparam logic [CODE_W-1:0] IND_RECOVERING = 3'd5;

    // Buzzer codes
    localparam logic [CODE_W-1:0] BUZ_SILENT    = 3'd0;
    localparam logic [CODE_W-1:0] BUZ_WARNING   = 3'd1;
    localparam logic [CODE_W-1:0] BUZ_SIREN     = 3'd2;
    localparam logic [CODE_W-1:0] BUZ_CONFIRMED = 3'd3;
    localparam logic [CODE_W-1:0] BUZ_RECOVERY  = 3'd4;

    typedef enum logic [CODE_W-1:0] {
        MODE_NORMAL     = 3'd0,
        MODE_DIZZY      = 3'd1,
        MODE_FALLEN     = 3'd2,
        MODE_ALARMED    = 3'd3,
        MODE_RECOVERING = 3'd4
    } mode_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_code;
        logic [TIME_W-1:0]  now_ms;
    } fam_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] indicator_code;
        logic [CODE_W-1:0] buzzer_code;
        logic              send_alert;
        logic              send_resolved;
    } fam_out_t;

endpackage

// ===== design/fall_alarm_mode_controller.sv =====
// ----------------------------------------------------------------------------
// fall_alarm_mode_controller
// Five-mode fall alarm machine stepped once per motion classification.
// ----------------------------------------------------------------------------
// Each input transaction carries one motion class and a millisecond timestamp
// and yields exactly one result transaction: the mode after the item, the
// held indicator and buzzer codes, and one-shot send_alert / send_resolved
// pulses. The block is a two-register pipeline (input register, then the
// mode update feeding the result register) and accepts one transaction per
// clock cycle as long as the result register is drained; an accepted input
// waits in the input register until the result register is empty or being
// emptied, and its result is then loaded into the result register.
// The whole mode step, including the wrapping 32-bit elapsed-time compare
// and the saturating confirmation counter, is combinational between the
// two registers. Configuration registers are written through the cfg port,
// which is always ready; write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module fall_alarm_mode_controller
    import fam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input transactions
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fam_in_t               in_data,
    // result transactions
    output logic                  out_valid,
    input  logic                  out_ready,
    output fam_out_t              out_data,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] alarm_confirm_reg;
    logic [COUNT_W-1:0] recover_confirm_reg;
    logic [DELAY_W-1:0] fall_delay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_confirm_reg   <= ALARM_CONFIRM_RESET;
            recover_confirm_reg <= RECOVER_CONFIRM_RESET;
            fall_delay_reg      <= FALL_DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            // Writes to indexes beyond the register list are dropped.
            case (cfg_index)
                CFG_ALARM_CONFIRM:   alarm_confirm_reg   <= cfg_data[COUNT_W-1:0];
                CFG_RECOVER_CONFIRM: recover_confirm_reg <= cfg_data[COUNT_W-1:0];
                CFG_FALL_DELAY:      fall_delay_reg      <= cfg_data[DELAY_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // Stage 1 holds the accepted transaction; stage 2 is the result
    // register. A stage advances whenever the stage after it is empty or
    // is being emptied this cycle.
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    fam_in_t s1_data_reg;
    logic    out_valid_reg;
    fam_out_t out_data_reg;

    logic s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // ------------------------------------------------------------------
    // Mode state
    // ------------------------------------------------------------------
    mode_t              mode_reg,      mode_next;
    logic [COUNT_W-1:0] cnt_reg,       cnt_next;
    logic [TIME_W-1:0]  fall_time_reg, fall_time_next;
    logic [CODE_W-1:0]  ind_reg,       ind_next;
    logic [CODE_W-1:0]  buz_reg,       buz_next;
    logic               alert_next;
    logic               resolved_next;

    logic [CLASS_W-1:0] cls;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  elapsed;
    logic               delay_met;
    logic               is_normal_motion;
    logic               is_recovery_sign;
    logic [COUNT_W-1:0] cnt_bump;

    assign cls = s1_data_reg.class_code;
    assign now = s1_data_reg.now_ms;

    // Wrapping elapsed time since the first fall reading.
    assign elapsed   = now - fall_time_reg;
    assign delay_met = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, fall_delay_reg};

    assign is_normal_motion = cls <= CLS_WALK;
    assign is_recovery_sign = cls <= CLS_DIZZY;

    // Saturating confirmation counter increment.
    assign cnt_bump = (cnt_reg == {COUNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        fall_time_next = fall_time_reg;
        ind_next       = ind_reg;
        buz_next       = buz_reg;
        alert_next     = 1'b0;
        resolved_next  = 1'b0;

        case (mode_reg)
            MODE_DIZZY:
            begin
                if (cls == CLS_FALL)
                begin
                    mode_next      = MODE_FALLEN;
                    ind_next       = IND_ALARMED;
                    buz_next       = BUZ_SIREN;
                    fall_time_next = now;
                    cnt_next       = '0;
                end
                else if (is_normal_motion)
                begin
                    mode_next = MODE_NORMAL;
                    ind_next  = cls;
                    buz_next  = BUZ_SILENT;
                end
            end

            MODE_FALLEN:
            begin
                // Escalate on any later item once the delay has run out.
                if (delay_met)
                begin
                    mode_next  = MODE_ALARMED;
                    ind_next   = IND_ALARMED;
                    buz_next   = BUZ_CONFIRMED;
                    cnt_next   = '0;
                    alert_next = 1'b1;
                end
            end

            MODE_ALARMED:
            begin
                if (is_recovery_sign)
                begin
                    if (cnt_bump >= alarm_confirm_reg)
                    begin
                        mode_next = MODE_RECOVERING;
                        ind_next  = IND_RECOVERING;
                        buz_next  = BUZ_RECOVERY;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_bump;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
            end

            MODE_RECOVERING:
            begin
                if (is_normal_motion)
                begin
                    if (cnt_bump >= recover_confirm_reg)
                    begin
                        mode_next     = MODE_NORMAL;
                        cnt_next      = '0;
                        ind_next      = cls;
                        buz_next      = BUZ_SILENT;
                        resolved_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_bump;
                    end
                end
                else if (cls == CLS_FALL)
                begin
                    // Fall during recovery re-alarms at once.
                    mode_next  = MODE_ALARMED;
                    ind_next   = IND_ALARMED;
                    buz_next   = BUZ_CONFIRMED;
                    cnt_next   = '0;
                    alert_next = 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                end
            end

            default:
            begin
                // Normal mode: track stand/sit/walk on the indicator.
                if (is_normal_motion)
                begin
                    ind_next = cls;
                end
                if (cls == CLS_FALL)
                begin
                    mode_next      = MODE_FALLEN;
                    ind_next       = IND_ALARMED;
                    buz_next       = BUZ_SIREN;
                    fall_time_next = now;
                    cnt_next       = '0;
                end
                else if (cls == CLS_DIZZY)
                begin
                    mode_next = MODE_DIZZY;
                    ind_next  = IND_DIZZY;
                    buz_next  = BUZ_WARNING;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_NORMAL;
            cnt_reg       <= '0;
            fall_time_reg <= '0;
            ind_reg       <= IND_STANDING;
            buz_reg       <= BUZ_SILENT;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                cnt_reg       <= cnt_next;
                fall_time_reg <= fall_time_next;
                ind_reg       <= ind_next;
                buz_reg       <= buz_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg.mode           <= mode_next;
            out_data_reg.indicator_code <= ind_next;
            out_data_reg.buzzer_code    <= buz_next;
            out_data_reg.send_alert     <= alert_next;
            out_data_reg.send_resolved  <= resolved_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_alert_in_alarmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_alert |-> out_data.mode == MODE_ALARMED)
        else $error("alert pulse without entering alarmed mode");

    a_resolved_in_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_resolved |->
            out_data.mode == MODE_NORMAL && out_data.buzzer_code == BUZ_SILENT)
        else $error("resolved pulse without returning to normal mode");

    a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.send_alert && out_data.send_resolved))
        else $error("alert and resolved pulses in one transaction");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_NORMAL || mode_reg == MODE_DIZZY || mode_reg == MODE_FALLEN
            |-> cnt_reg == '0)
        else $error("confirmation counter running outside alarm/recovery");

    a_fallen_siren: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_FALLEN |-> buz_reg == BUZ_SIREN && ind_reg == IND_ALARMED)
        else $error("fallen mode without siren and alarm indicator");

endmodule

// ===== sim/tb_fall_alarm_mode_controller.sv =====
// ----------------------------------------------------------------------------
// tb_fall_alarm_mode_controller
// Self-checking testbench for the fall alarm mode controller.
// ----------------------------------------------------------------------------
// A short directed sequence walks every mode, and each transition but normal
// to fallen, at the register reset values: spare class codes, dizzy and back,
// a fall timed across the 32-bit wrap of the millisecond clock, counter
// clears in alarmed and in recovering, a re-alarm from recovering, and a
// resolved return to normal. Then six register settings follow, the
// extremes among them, each fed with random fall / dizzy / noise episodes.
// A built-in mode predictor computes the expected result of every accepted
// reading, and the monitor compares each result field by field. Both sides
// idle at random, except for one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_fall_alarm_mode_controller;
    import fam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Motion classes that the package leaves unnamed
    localparam logic [CLASS_W-1:0] CLS_STAND  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SIT    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_OTHER  = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_SPARE6 = 3'd6;
    localparam logic [CLASS_W-1:0] CLS_SPARE7 = 3'd7;

    // Register index that maps to no register; a write to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned IDLE_PCT    = 19;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Fall start just below the wrap so that the delay is measured across it
    localparam logic [TIME_W-1:0] WRAP_FALL_MS = 32'hFFFF_F800;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    fam_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    fam_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ALARM_CONFIRM;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Readings waiting to be driven, and alarm outputs waiting to be seen
    fam_in_t  reading_q[$];
    fam_out_t awaited_q[$];

    // Predictor copy of the block state and registers
    mode_t              cur_mode;
    logic [COUNT_W-1:0] confirm_cnt;
    logic [TIME_W-1:0]  fall_t0;
    logic [CODE_W-1:0]  ind_q;
    logic [CODE_W-1:0]  buz_q;
    logic [COUNT_W-1:0] alarm_need;
    logic [COUNT_W-1:0] recover_need;
    logic [DELAY_W-1:0] fall_delay;

    // Millisecond clock used to stamp generated readings
    logic [TIME_W-1:0] ms_clock = '0;

    // Full rate on both sides while set
    logic steady = 1'b0;

    int unsigned issued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned result_cnt   = 0;
    int unsigned err_cnt      = 0;
    int unsigned alert_cnt    = 0;
    int unsigned resolved_cnt = 0;
    int unsigned setting_cnt  = 0;
    int unsigned cycle_cnt    = 0;

    fam_out_t want;

    fall_alarm_mode_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mode predictor
    // ------------------------------------------------------------------------

    function automatic void enter_fallen(logic [TIME_W-1:0] now);
        cur_mode    = MODE_FALLEN;
        ind_q       = IND_ALARMED;
        buz_q       = BUZ_SIREN;
        fall_t0     = now;
        confirm_cnt = '0;
    endfunction

    function automatic void enter_alarmed();
        cur_mode    = MODE_ALARMED;
        ind_q       = IND_ALARMED;
        buz_q       = BUZ_CONFIRMED;
        confirm_cnt = '0;
    endfunction

    // Saturate at the counter's full scale
    function automatic void bump_confirm();
        if (confirm_cnt != '1)
            confirm_cnt = confirm_cnt + 1'b1;
    endfunction

    // Step the mode machine by one reading and return the alarm outputs
    function automatic fam_out_t advance_alarm(fam_in_t item);
        logic [CLASS_W-1:0] cls;
        logic [TIME_W-1:0]  elapsed;
        fam_out_t           res;
        cls               = item.class_code;
        res.send_alert    = 1'b0;
        res.send_resolved = 1'b0;
        case (cur_mode)
            MODE_DIZZY:
            begin
                if (cls == CLS_FALL)
                    enter_fallen(item.now_ms);
                else if (cls <= CLS_WALK)
                begin
                    cur_mode = MODE_NORMAL;
                    ind_q    = cls;
                    buz_q    = BUZ_SILENT;
                end
            end
            MODE_FALLEN:
            begin
                // Wrapping difference, so a fall across the rollover still times out
                elapsed = item.now_ms - fall_t0;
                if (elapsed >= fall_delay)
                begin
                    enter_alarmed();
                    res.send_alert = 1'b1;
                end
            end
            MODE_ALARMED:
            begin
                if (cls <= CLS_DIZZY)
                begin
                    bump_confirm();
                    if (confirm_cnt >= alarm_need)
                    begin
                        cur_mode    = MODE_RECOVERING;
                        ind_q       = IND_RECOVERING;
                        buz_q       = BUZ_RECOVERY;
                        confirm_cnt = '0;
                    end
                end
                else
                    confirm_cnt = '0;
            end
            MODE_RECOVERING:
            begin
                if (cls <= CLS_WALK)
                begin
                    bump_confirm();
                    if (confirm_cnt >= recover_need)
                    begin
                        cur_mode          = MODE_NORMAL;
                        confirm_cnt       = '0;
                        ind_q             = cls;
                        buz_q             = BUZ_SILENT;
                        res.send_resolved = 1'b1;
                    end
                end
                else if (cls == CLS_FALL)
                begin
                    enter_alarmed();
                    res.send_alert = 1'b1;
                end
                else
                    confirm_cnt = '0;
            end
            default:
            begin
                if (cls <= CLS_WALK)
                    ind_q = cls;
                if (cls == CLS_FALL)
                    enter_fallen(item.now_ms);
                else if (cls == CLS_DIZZY)
                begin
                    cur_mode = MODE_DIZZY;
                    ind_q    = IND_DIZZY;
                    buz_q    = BUZ_WARNING;
                end
                else
                    cur_mode = MODE_NORMAL;
            end
        endcase
        res.mode           = cur_mode;
        res.indicator_code = ind_q;
        res.buzzer_code    = buz_q;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pull the next reading when the input slot frees up
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // Predict on acceptance so the expectation follows the block's order
            if (in_valid && in_ready)
            begin
                awaited_q.push_back(advance_alarm(in_data));
                accepted_cnt++;
            end
            // Hold valid and payload until the transaction completes
            if (!in_valid || in_ready)
            begin
                if (reading_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_data  <= reading_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result against the oldest expectation
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
        $display("ERROR result %0d: %s got %0d, expected %0d", result_cnt, what, got,
                 exp_val);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch("unexpected result, mode", out_data.mode, 0);
                else
                begin
                    want = awaited_q.pop_front();
                    if (out_data.mode !== want.mode)
                        report_mismatch("mode", out_data.mode, want.mode);
                    if (out_data.indicator_code !== want.indicator_code)
                        report_mismatch("indicator_code", out_data.indicator_code,
                                        want.indicator_code);
                    if (out_data.buzzer_code !== want.buzzer_code)
                        report_mismatch("buzzer_code", out_data.buzzer_code,
                                        want.buzzer_code);
                    if (out_data.send_alert !== want.send_alert)
                        report_mismatch("send_alert", out_data.send_alert, want.send_alert);
                    if (out_data.send_resolved !== want.send_resolved)
                        report_mismatch("send_resolved", out_data.send_resolved,
                                        want.send_resolved);
                    alert_cnt    += want.send_alert;
                    resolved_cnt += want.send_resolved;
                end
                result_cnt++;
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Advance the millisecond clock by gap and queue one reading stamped with it
    task automatic queue_item(logic [CLASS_W-1:0] cls, int unsigned gap);
        fam_in_t item;
        ms_clock        = ms_clock + gap;
        item.class_code = cls;
        item.now_ms     = ms_clock;
        reading_q.push_back(item);
        issued_cnt++;
    endtask

    // Wait until every issued reading has its result, then let the pipe settle
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || awaited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Mirror the write into the predictor
        case (idx)
            CFG_ALARM_CONFIRM:   alarm_need   = val[COUNT_W-1:0];
            CFG_RECOVER_CONFIRM: recover_need = val[COUNT_W-1:0];
            CFG_FALL_DELAY:      fall_delay   = val[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // Random readings, any class, sometimes at an arbitrary absolute time
    task automatic queue_noise();
        logic [CLASS_W-1:0] cls;
        repeat ($urandom_range(1, 6))
        begin
            cls = CLASS_W'($urandom_range(CLS_STAND, CLS_SPARE7));
            if ($urandom_range(0, 3) == 0)
            begin
                ms_clock = $urandom;
                queue_item(cls, 0);
            end
            else
                queue_item(cls, $urandom_range(0, 5000));
        end
    endtask

    // Dizzy spell: dizzy, some non-motion readings, then back to motion or a fall
    task automatic queue_dizzy_spell();
        logic [CLASS_W-1:0] cls;
        queue_item(CLS_DIZZY, $urandom_range(0, 3000));
        repeat ($urandom_range(0, 3))
        begin
            cls = CLASS_W'($urandom_range(CLS_DIZZY, CLS_SPARE7));
            if (cls == CLS_FALL)
                cls = CLS_DIZZY;
            queue_item(cls, $urandom_range(0, 1000));
        end
        if ($urandom_range(0, 3) == 0)
            queue_item(CLS_FALL, $urandom_range(0, 1000));
        else
            queue_item(CLASS_W'($urandom_range(CLS_STAND, CLS_WALK)),
                       $urandom_range(0, 1000));
    endtask

    // Full fall episode: fall, wait out the delay, recover, resolve.
    // A few episodes are cut short or broken by clearing readings.
    task automatic queue_fall_episode();
        int unsigned        span;
        int unsigned        gap;
        int unsigned        need;
        int unsigned        n;
        int unsigned        roll;
        logic               at_boundary;
        logic [CLASS_W-1:0] cls;
        if ($urandom_range(0, 19) == 0)
            ms_clock = $urandom;
        queue_item(CLS_FALL, $urandom_range(0, 2000));

        // Fallen: any class, time steps until the delay is reached;
        // sometimes land one ms short of it first
        span        = 0;
        n           = 0;
        at_boundary = ($urandom_range(0, 2) == 0);
        do
        begin
            gap = $urandom_range(1, fall_delay / 3 + 1);
            if (at_boundary && span + 1 == fall_delay)
                gap = 1;
            else if (at_boundary && span + 1 < fall_delay && span + gap >= fall_delay)
                gap = fall_delay - span - 1;
            span += gap;
            n++;
            queue_item(CLASS_W'($urandom_range(CLS_STAND, CLS_SPARE7)), gap);
        end
        while (span < fall_delay && n < 12);
        if ($urandom_range(0, 9) == 0)
            return;

        // Alarmed: recovery signs, now and then a fall or other to clear the count
        need = (alarm_need == 0 ? 1 : alarm_need) + $urandom_range(0, 1);
        for (n = 0; n < need; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                cls = CLASS_W'($urandom_range(CLS_FALL, CLS_SPARE7));
            else
                cls = CLASS_W'($urandom_range(CLS_STAND, CLS_DIZZY));
            queue_item(cls, $urandom_range(0, 1500));
        end

        // Recovering: normal motion, rarely a clear or a re-alarm
        need = (recover_need == 0 ? 1 : recover_need) + $urandom_range(0, 1);
        for (n = 0; n < need; n++)
        begin
            roll = $urandom_range(0, 29);
            if (roll == 0)
                cls = CLS_FALL;
            else if (roll < 4)
            begin
                cls = CLASS_W'($urandom_range(CLS_DIZZY, CLS_SPARE7));
                if (cls == CLS_FALL)
                    cls = CLS_OTHER;
            end
            else
                cls = CLASS_W'($urandom_range(CLS_STAND, CLS_WALK));
            queue_item(cls, $urandom_range(0, 1500));
        end
    endtask

    // One register setting: write every register while idle, then random episodes
    task automatic run_phase(logic [COUNT_W-1:0] a_need, logic [COUNT_W-1:0] r_need,
                             logic [DELAY_W-1:0] delay, int unsigned budget, logic quiet);
        int unsigned start;
        int unsigned kind;
        wait_idle();
        write_reg(CFG_ALARM_CONFIRM, CFG_DATA_W'(a_need));
        write_reg(CFG_RECOVER_CONFIRM, CFG_DATA_W'(r_need));
        write_reg(CFG_FALL_DELAY, delay);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        steady = quiet;
        setting_cnt++;
        start = issued_cnt;
        while (issued_cnt - start < budget)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
                queue_noise();
            else if (kind < 4)
                queue_dizzy_spell();
            else
                queue_fall_episode();
            // Now and then hold the sender until every result is back
            if ($urandom_range(0, 11) == 0)
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cur_mode     = MODE_NORMAL;
        confirm_cnt  = '0;
        fall_t0      = '0;
        ind_q        = IND_STANDING;
        buz_q        = BUZ_SILENT;
        alarm_need   = ALARM_CONFIRM_RESET;
        recover_need = RECOVER_CONFIRM_RESET;
        fall_delay   = FALL_DELAY_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through every mode at the reset register values.
        // Spare class code in normal leaves the indicator alone; then motions.
        queue_item(CLS_SPARE7, 100);
        queue_item(CLS_STAND, 100);
        queue_item(CLS_SIT, 100);
        queue_item(CLS_WALK, 100);
        // Dizzy, an ignored reading, back to normal on motion
        queue_item(CLS_DIZZY, 100);
        queue_item(CLS_OTHER, 100);
        queue_item(CLS_WALK, 100);
        // Dizzy into a fall just below the rollover of the ms clock
        queue_item(CLS_DIZZY, 100);
        ms_clock = WRAP_FALL_MS;
        queue_item(CLS_FALL, 0);
        // One ms short of the delay after the wrap, then exactly on it
        queue_item(CLS_STAND, FALL_DELAY_RESET - 1);
        queue_item(CLS_OTHER, 1);
        // Alarmed: other clears the count, then three recovery signs
        queue_item(CLS_STAND, 100);
        queue_item(CLS_OTHER, 100);
        queue_item(CLS_SIT, 100);
        queue_item(CLS_WALK, 100);
        queue_item(CLS_DIZZY, 100);
        // Recovering: dizzy clears, a fall re-alarms at once
        queue_item(CLS_DIZZY, 100);
        queue_item(CLS_FALL, 100);
        // Alarmed again: a fall clears, then back to recovering
        queue_item(CLS_FALL, 100);
        repeat (3) queue_item(CLS_SIT, 100);
        // Recovering: five walks resolve to normal
        repeat (5) queue_item(CLS_WALK, 100);

        // Random part over several register settings.
        // Reset values at full rate on both sides.
        run_phase(ALARM_CONFIRM_RESET, RECOVER_CONFIRM_RESET, FALL_DELAY_RESET, 200, 1'b1);
        // Lowest thresholds and no delay: alarm on the first reading after a fall
        run_phase(8'd1, 8'd1, 16'd0, 200, 1'b0);
        // Highest thresholds and longest delay; one full episode runs to about 500 readings
        run_phase(8'd255, 8'd255, 16'hFFFF, 50, 1'b0);
        // Zero thresholds behave like one
        run_phase(8'd0, 8'd0, 16'd1, 150, 1'b0);
        run_phase(COUNT_W'($urandom_range(1, 8)), COUNT_W'($urandom_range(1, 8)),
                  DELAY_W'($urandom_range(0, 65535)), 150, 1'b0);
        run_phase(COUNT_W'($urandom_range(2, 20)), COUNT_W'($urandom_range(2, 20)),
                  DELAY_W'($urandom_range(0, 65535)), 150, 1'b0);

        wait_idle();

        $display("Checked %0d readings and %0d results over %0d register settings",
                 accepted_cnt, result_cnt, setting_cnt);
        $display("Alerts raised: %0d, resolved messages: %0d, errors: %0d",
                 alert_cnt, resolved_cnt, err_cnt);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fall_alarm_mode_controller.f =====
design/fam_pkg.sv
design/fall_alarm_mode_controller.sv
sim/tb_fall_alarm_mode_controller.sv
